FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every rising clock edge, skipped while in reset.
`define ASSERT_IMPL(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Check that a condition is followed by another in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

FILE: hw/rtl/flha_pkg.sv
// Shared types and constants of the free-list heap allocator.
package flha_pkg;

    localparam int DEF_ARENA_UNITS = 4096;
    localparam int DEF_UNIT_BYTES  = 8;
    localparam int PAYLOAD_W       = 12;
    localparam int BYTES_W         = 15;
    localparam int FREE_IDX_W      = 12;
    localparam int NEED_W          = 14;
    localparam int RECIP_SHIFT     = 20;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISP,
        ST_NEED,
        ST_SCAN,
        ST_SPLIT,
        ST_FWALK,
        ST_FBP,
        ST_FQ,
        ST_FLOW
    } flha_state_t;

endpackage

FILE: hw/rtl/flha_hdr_mem.sv
// Header memory: next pointer and size per unit, one registered read port.
module flha_hdr_mem
    import flha_pkg::*;
#(
    parameter int ARENA_UNITS = DEF_ARENA_UNITS,
    parameter int AW = $clog2(ARENA_UNITS),
    parameter int SW = $clog2(ARENA_UNITS + 1)
) (
    input  logic          clk,
    input  logic [AW-1:0] rd_addr,
    output logic [AW-1:0] rd_next,
    output logic [SW-1:0] rd_size,
    input  logic          next_we,
    input  logic [AW-1:0] next_waddr,
    input  logic [AW-1:0] next_wdata,
    input  logic          size_we,
    input  logic [AW-1:0] size_waddr,
    input  logic [SW-1:0] size_wdata
);

    logic [AW-1:0] next_mem [ARENA_UNITS];
    logic [SW-1:0] size_mem [ARENA_UNITS];
    logic [AW-1:0] rd_next_reg;
    logic [SW-1:0] rd_size_reg;

    always_ff @(posedge clk)
    begin
        if (next_we)
        begin
            next_mem[next_waddr] <= next_wdata;
        end
        if (size_we)
        begin
            size_mem[size_waddr] <= size_wdata;
        end
        rd_next_reg <= next_mem[rd_addr];
        rd_size_reg <= size_mem[rd_addr];
    end

    assign rd_next = rd_next_reg;
    assign rd_size = rd_size_reg;

endmodule

FILE: hw/rtl/free_list_heap_allocator.sv
// Top level of the next-fit free-list heap allocator.
//
// A command is taken when start is high and busy is low; busy then stays
// high until the single result is shown on payload_index and failed for one
// cycle with done high. The receiver cannot stall, so capture the result in
// that cycle. One header memory read per cycle sets the pace: an allocate
// scans one free block per read in ST_SCAN, and ST_SPLIT finishes a split;
// a free walks one list step per read, then merges starting in ST_FBP.
// A walk visits at most ARENA_UNITS + 1 blocks. The arena is laid out as one
// free block by the first command; there is no clearing pass after reset.
`include "assert_macros.svh"

module free_list_heap_allocator
    import flha_pkg::*;
#(
    parameter int ARENA_UNITS = DEF_ARENA_UNITS,
    parameter int UNIT_BYTES  = DEF_UNIT_BYTES
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  op,
    input  logic [BYTES_W-1:0]    request_bytes,
    input  logic [FREE_IDX_W-1:0] free_index,
    output logic                  done,
    output logic [PAYLOAD_W-1:0]  payload_index,
    output logic                  failed
);

    localparam int AW    = $clog2(ARENA_UNITS);
    localparam int SW    = $clog2(ARENA_UNITS + 1);
    localparam int XW    = AW + 2;
    localparam int CW    = ((SW > NEED_W) ? SW : NEED_W) + 1;
    localparam int STW   = $clog2(ARENA_UNITS + 2);
    localparam int RECIP = (1 << RECIP_SHIFT) / UNIT_BYTES;
    localparam int RW    = $clog2(RECIP + 1);
    localparam int PW    = BYTES_W + 1 + RW;

    localparam logic [XW-1:0]  AU     = XW'(ARENA_UNITS);
    localparam logic [STW-1:0] ST_MAX = STW'(ARENA_UNITS);

    // Reduce a header index modulo the arena size.
    function automatic logic [AW-1:0] ix(input logic [XW-1:0] x);
        logic [XW-1:0] v;
        v = x;
        for (int i = 0; i < 3; i++)
        begin
            if (v >= AU)
            begin
                v = v - AU;
            end
        end
        return v[AW-1:0];
    endfunction

    flha_state_t state_reg, state_next;

    logic                  op_reg;
    logic [BYTES_W-1:0]    bytes_reg;
    logic [FREE_IDX_W-1:0] fidx_reg;
    logic [AW-1:0]         rover_reg, rover_next;
    logic                  empty_reg, empty_next;
    logic                  init_reg, init_next;
    logic [AW-1:0]         prev_reg, prev_next;
    logic [AW-1:0]         cur_reg, cur_next;
    logic [AW-1:0]         p_reg, p_next;
    logic [AW-1:0]         q_reg, q_next;
    logic [AW-1:0]         bp_reg, bp_next;
    logic [SW-1:0]         psz_reg, psz_next;
    logic [SW-1:0]         bpsz_reg, bpsz_next;
    logic [SW-1:0]         nbsz_reg, nbsz_next;
    logic [AW-1:0]         nbnext_reg, nbnext_next;
    logic                  low_reg, low_next;
    logic [NEED_W-1:0]     need_reg, need_next;
    logic [PW-1:0]         prod_reg, prod_next;
    logic [STW-1:0]        steps_reg, steps_next;
    logic                  done_reg, done_next;
    logic [PAYLOAD_W-1:0]  pay_reg, pay_next;
    logic                  fail_reg, fail_next;

    logic [AW-1:0] rd_addr, rd_next;
    logic [SW-1:0] rd_size;
    logic          next_we, size_we;
    logic [AW-1:0] next_waddr, next_wdata, size_waddr;
    logic [SW-1:0] size_wdata;

    logic [BYTES_W:0]  bytes_up;
    logic [NEED_W-1:0] q_est;
    logic [BYTES_W:0]  rem;
    logic [CW-1:0]     sz_c, need_c;
    logic [AW-1:0]     walk_q;
    logic [XW-1:0]     bp_end, p_end;
    logic [FREE_IDX_W:0] fidx_m1;
    logic              upper, lower, sole;

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign payload_index = pay_reg;
    assign failed = fail_reg;

    flha_hdr_mem #(
        .ARENA_UNITS(ARENA_UNITS),
        .AW(AW),
        .SW(SW)
    ) u_hdr_mem (
        .clk       (clk),
        .rd_addr   (rd_addr),
        .rd_next   (rd_next),
        .rd_size   (rd_size),
        .next_we   (next_we),
        .next_waddr(next_waddr),
        .next_wdata(next_wdata),
        .size_we   (size_we),
        .size_waddr(size_waddr),
        .size_wdata(size_wdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rover_reg <= '0;
            empty_reg <= 1'b0;
            init_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rover_reg <= rover_next;
            empty_reg <= empty_next;
            init_reg  <= init_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            op_reg    <= op;
            bytes_reg <= request_bytes;
            fidx_reg  <= free_index;
        end
        prev_reg   <= prev_next;
        cur_reg    <= cur_next;
        p_reg      <= p_next;
        q_reg      <= q_next;
        bp_reg     <= bp_next;
        psz_reg    <= psz_next;
        bpsz_reg   <= bpsz_next;
        nbsz_reg   <= nbsz_next;
        nbnext_reg <= nbnext_next;
        low_reg    <= low_next;
        need_reg   <= need_next;
        prod_reg   <= prod_next;
        steps_reg  <= steps_next;
        pay_reg    <= pay_next;
        fail_reg   <= fail_next;
    end

    // Shared arithmetic terms.
    always_comb
    begin
        bytes_up = {1'b0, bytes_reg} + (BYTES_W+1)'(UNIT_BYTES - 1);
        q_est    = NEED_W'(prod_reg >> RECIP_SHIFT);
        rem      = bytes_up - (BYTES_W+1)'(q_est * UNIT_BYTES);
        sz_c     = CW'(rd_size);
        need_c   = CW'(need_reg);
        walk_q   = ix(XW'(rd_next));
        fidx_m1  = {1'b0, fidx_reg} - 1'b1;
        bp_end   = XW'(bp_reg) + XW'(bpsz_reg);
        p_end    = XW'(p_reg) + XW'(psz_reg);
        sole     = (q_reg == p_reg);
        upper    = (bp_end == XW'(q_reg));
        lower    = (p_end == XW'(bp_reg));
    end

    always_comb
    begin
        state_next  = state_reg;
        rover_next  = rover_reg;
        empty_next  = empty_reg;
        init_next   = init_reg;
        prev_next   = prev_reg;
        cur_next    = cur_reg;
        p_next      = p_reg;
        q_next      = q_reg;
        bp_next     = bp_reg;
        psz_next    = psz_reg;
        bpsz_next   = bpsz_reg;
        nbsz_next   = nbsz_reg;
        nbnext_next = nbnext_reg;
        low_next    = low_reg;
        need_next   = need_reg;
        prod_next   = prod_reg;
        steps_next  = steps_reg;
        done_next   = 1'b0;
        pay_next    = pay_reg;
        fail_next   = fail_reg;
        rd_addr     = rover_reg;
        next_we     = 1'b0;
        next_waddr  = '0;
        next_wdata  = '0;
        size_we     = 1'b0;
        size_waddr  = '0;
        size_wdata  = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_DISP;
                    // Lay the arena out as one self-linked block on first use.
                    if (!init_reg)
                    begin
                        init_next  = 1'b1;
                        next_we    = 1'b1;
                        size_we    = 1'b1;
                        size_wdata = SW'(ARENA_UNITS);
                        rover_next = '0;
                        empty_next = 1'b0;
                    end
                end
            end

            ST_DISP:
            begin
                bp_next = AW'(fidx_m1);
                if (op_reg == OP_ALLOC)
                begin
                    if (bytes_reg == '0 || empty_reg)
                    begin
                        state_next = ST_IDLE;
                        done_next  = 1'b1;
                        pay_next   = '0;
                        fail_next  = 1'b1;
                    end
                    else
                    begin
                        prod_next  = PW'(bytes_up) * PW'(RECIP);
                        state_next = ST_NEED;
                    end
                end
                else if (fidx_reg == '0 || (32'(fidx_m1) >= ARENA_UNITS))
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                    pay_next   = '0;
                    fail_next  = 1'b0;
                end
                else if (empty_reg)
                begin
                    next_we    = 1'b1;
                    next_waddr = AW'(fidx_m1);
                    next_wdata = AW'(fidx_m1);
                    rover_next = AW'(fidx_m1);
                    empty_next = 1'b0;
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                    pay_next   = '0;
                    fail_next  = 1'b0;
                end
                else
                begin
                    p_next     = rover_reg;
                    steps_next = '0;
                    state_next = ST_FWALK;
                end
            end

            ST_NEED:
            begin
                // Correct the reciprocal quotient, then add the header unit.
                if (rem >= (BYTES_W+1)'(UNIT_BYTES))
                begin
                    need_next = q_est + NEED_W'(2);
                end
                else
                begin
                    need_next = q_est + NEED_W'(1);
                end
                prev_next  = rover_reg;
                cur_next   = walk_q;
                rd_addr    = walk_q;
                steps_next = '0;
                state_next = ST_SCAN;
            end

            ST_SCAN:
            begin
                if (steps_reg > ST_MAX)
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                    pay_next   = '0;
                    fail_next  = 1'b1;
                end
                else if (sz_c == need_c)
                begin
                    // Exact fit: unlink, or drain the list on its last block.
                    if (cur_reg == prev_reg)
                    begin
                        empty_next = 1'b1;
                    end
                    else
                    begin
                        next_we    = 1'b1;
                        next_waddr = prev_reg;
                        next_wdata = rd_next;
                    end
                    rover_next = prev_reg;
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                    pay_next   = PAYLOAD_W'({1'b0, cur_reg} + 1'b1);
                    fail_next  = 1'b0;
                end
                else if (sz_c > need_c)
                begin
                    // Split: shrink the block, hand out its upper part.
                    size_we    = 1'b1;
                    size_waddr = cur_reg;
                    size_wdata = SW'(sz_c - need_c);
                    cur_next   = ix(XW'(cur_reg) + XW'(sz_c - need_c));
                    rover_next = prev_reg;
                    state_next = ST_SPLIT;
                end
                else if (cur_reg == rover_reg)
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                    pay_next   = '0;
                    fail_next  = 1'b1;
                end
                else
                begin
                    prev_next  = cur_reg;
                    cur_next   = walk_q;
                    rd_addr    = walk_q;
                    steps_next = steps_reg + 1'b1;
                end
            end

            ST_SPLIT:
            begin
                size_we    = 1'b1;
                size_waddr = cur_reg;
                size_wdata = SW'(need_reg);
                state_next = ST_IDLE;
                done_next  = 1'b1;
                pay_next   = PAYLOAD_W'({1'b0, cur_reg} + 1'b1);
                fail_next  = 1'b0;
            end

            ST_FWALK:
            begin
                if (steps_reg > ST_MAX)
                begin
                    // No insertion point: drop the free.
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                    pay_next   = '0;
                    fail_next  = 1'b0;
                end
                else if ((bp_reg > p_reg && bp_reg < walk_q) ||
                         (p_reg >= walk_q && (bp_reg > p_reg || bp_reg < walk_q)))
                begin
                    psz_next   = rd_size;
                    q_next     = walk_q;
                    rd_addr    = bp_reg;
                    state_next = ST_FBP;
                end
                else
                begin
                    p_next     = walk_q;
                    rd_addr    = walk_q;
                    steps_next = steps_reg + 1'b1;
                end
            end

            ST_FBP:
            begin
                bpsz_next  = rd_size;
                rd_addr    = q_reg;
                state_next = ST_FQ;
            end

            ST_FQ:
            begin
                low_next = lower;
                if (sole && upper)
                begin
                    // Freed block sits just below the sole block: merge.
                    size_we    = 1'b1;
                    size_waddr = bp_reg;
                    size_wdata = bpsz_reg + rd_size;
                    next_we    = 1'b1;
                    next_waddr = bp_reg;
                    next_wdata = bp_reg;
                    rover_next = bp_reg;
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                    pay_next   = '0;
                    fail_next  = 1'b0;
                end
                else
                begin
                    if (upper)
                    begin
                        nbsz_next   = bpsz_reg + rd_size;
                        nbnext_next = ix(XW'(rd_next));
                    end
                    else
                    begin
                        nbsz_next   = bpsz_reg;
                        nbnext_next = q_reg;
                    end
                    // Leave the freed header alone when it folds into the sole block.
                    if (!(sole && lower))
                    begin
                        size_we    = 1'b1;
                        size_waddr = bp_reg;
                        size_wdata = nbsz_next;
                        next_we    = 1'b1;
                        next_waddr = bp_reg;
                        next_wdata = nbnext_next;
                    end
                    rover_next = p_reg;
                    state_next = ST_FLOW;
                end
            end

            ST_FLOW:
            begin
                next_we    = 1'b1;
                next_waddr = p_reg;
                if (low_reg)
                begin
                    size_we    = 1'b1;
                    size_waddr = p_reg;
                    size_wdata = psz_reg + nbsz_reg;
                    next_wdata = nbnext_reg;
                end
                else
                begin
                    next_wdata = bp_reg;
                end
                state_next = ST_IDLE;
                done_next  = 1'b1;
                pay_next   = '0;
                fail_next  = 1'b0;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `ASSERT_IMPL(a_done_idle, clk, rst_n, done_reg, state_reg == ST_IDLE, "result while busy")
    `ASSERT_NEXT(a_take_busy, clk, rst_n, start && !busy, busy, "command taken but not busy")
    `ASSERT_IMPL(a_fail_zero, clk, rst_n, done_reg && fail_reg, pay_reg == '0, "failed with index")

endmodule
